// File: rtl/core/blstk_pkg.sv
// Shared types and codes for the bounded LIFO stack.
package blstk_pkg;

    // Command codes
    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP       = 3'd1;
    localparam logic [2:0] CMD_PEEK      = 3'd2;
    localparam logic [2:0] CMD_DUMP_UP   = 3'd3;
    localparam logic [2:0] CMD_DUMP_DOWN = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam int CAP_W   = 5;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [WORD_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data_word;
        logic [1:0]               status;
        logic                     last_of_run;
        logic [COUNT_W-1:0]       entry_count;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PEEK,
        ST_DUMP
    } state_t;

endpackage

// File: rtl/core/bounded_lifo_stack.sv
// Bounded LIFO stack of signed words held in a one-port-read synchronous memory.
//
// Usage:
//   Commands enter on item (cmd, push_value) and transfer at a rising edge with
//   start high and busy low. Each result is driven on result for exactly one
//   cycle with done high; the receiver cannot stall, so every result is taken
//   in the cycle it appears.
//   Push, pop, unknown commands and any command on an empty stack: result in the
//   next cycle after the transfer, busy stays low, so one command per cycle.
//   Peek of a held entry: one memory read, result registered from the read
//   data in the peek state, busy high for one cycle.
//   Dump of n entries: one memory read per cycle through the single read
//   port, n results back to back, each registered from the read data in the
//   dump state, last_of_run on the final one, busy high while the dump runs.
//   Capacity register: written over cfg_valid/cfg_ready/cfg_data, ready while
//   not busy; a value above DEPTH acts as DEPTH, zero makes every push full.
//   Reset: stack empty, capacity 16, no result pending. The entry memory is
//   not cleared; only entries below the fill count are ever read.
module bounded_lifo_stack #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  blstk_pkg::in_item_t          item,
    output logic                         done,
    output blstk_pkg::out_item_t         result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [blstk_pkg::CAP_W-1:0]  cfg_data
);
    import blstk_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);          // fill count width
    localparam int AW   = $clog2(DEPTH);              // memory address width
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;  // compare width

    // Entry memory: one write port, one registered read port
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    // Control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CAP_W-1:0] cap_reg;
    logic [AW-1:0]  addr_reg, addr_next;      // next dump read address
    logic [CW-1:0]  left_reg, left_next;      // dump results still to emit
    logic           dir_up_reg, dir_up_next;
    logic           done_reg, done_next;
    out_item_t      result_reg, result_next;

    // Derived values
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] eff_cap;
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] count_next_ext;
    logic            is_full;
    logic            is_empty;
    logic [AW-1:0]   top_addr;
    logic [63:0]     push_ext;
    logic [63:0]     rd_ext;
    logic [WORD_W-1:0] rd_word;

    assign cap_ext        = CMPW'(cap_reg);
    assign eff_cap        = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
    assign count_ext      = CMPW'(count_reg);
    assign count_next_ext = CMPW'(count_next);
    assign is_full        = (count_ext >= eff_cap);
    assign is_empty       = (count_reg == '0);
    assign top_addr       = AW'(count_reg - CW'(1));

    // Stored words are the low DATA_WIDTH bits of the zero-extended input word
    assign push_ext = {32'b0, item.push_value};
    assign wr_data  = DATA_WIDTH'(push_ext);
    assign rd_ext   = 64'(rd_data_reg);
    assign rd_word  = rd_ext[WORD_W-1:0];

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            cap_reg    <= CAP_W'(16);
            addr_reg   <= '0;
            left_reg   <= '0;
            dir_up_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            left_reg   <= left_next;
            dir_up_reg <= dir_up_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Result payload carries no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        dir_up_next = dir_up_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        rd_en       = 1'b0;
        rd_addr     = addr_reg;
        result_next = result_reg;
        result_next.data_word   = '0;
        result_next.status      = STAT_OK;
        result_next.last_of_run = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (item.cmd)
                        CMD_PUSH:
                        begin
                            if (is_full)
                            begin
                                result_next.status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = top_addr;
                                state_next = ST_PEEK;
                            end
                        end
                        CMD_DUMP_UP, CMD_DUMP_DOWN:
                        begin
                            if (is_empty)
                            begin
                                result_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                done_next   = 1'b0;
                                rd_en       = 1'b1;
                                left_next   = count_reg;
                                dir_up_next = (item.cmd == CMD_DUMP_UP);
                                state_next  = ST_DUMP;
                                if (item.cmd == CMD_DUMP_UP)
                                begin
                                    rd_addr   = '0;
                                    addr_next = AW'(1);
                                end
                                else
                                begin
                                    rd_addr   = top_addr;
                                    addr_next = top_addr - AW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // unknown command: plain ok result, no change
                        end
                    endcase
                end
            end
            ST_PEEK:
            begin
                done_next             = 1'b1;
                result_next.data_word = rd_word;
                state_next            = ST_IDLE;
            end
            ST_DUMP:
            begin
                done_next               = 1'b1;
                result_next.data_word   = rd_word;
                result_next.last_of_run = (left_reg == CW'(1));
                left_next               = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // read ahead the next entry while this one is emitted
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg;
                    addr_next = dir_up_reg ? (addr_reg + AW'(1)) : (addr_reg - AW'(1));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result_next.entry_count = count_next_ext[COUNT_W-1:0];
    end

    // Fill count never exceeds the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    // A dump in progress always has a result left to emit
    a_dump_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (left_reg != '0))
        else $error("dump running with nothing left");

    // Results of one dump come on consecutive cycles
    a_dump_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last_of_run) |=> done)
        else $error("gap inside a dump run");

    // A full report leaves the fill count unchanged
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd == CMD_PUSH && is_full) |=> $stable(count_reg))
        else $error("fill count moved on a full push");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the bounded LIFO stack: directed and random commands.
`timescale 1ns / 100ps

module tb;
    import blstk_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_PERCENT = 37;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // Clock, reset and all block inputs start at known values.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_item_t item = '0;
    logic cfg_valid = 1'b0;
    logic [CAP_W-1:0] cfg_data = '0;

    logic busy;
    logic done;
    out_item_t result;
    logic cfg_ready;

    // Predictor state: held words, fill level and capacity register.
    logic signed [WORD_W-1:0] held_words [STACK_DEPTH];
    int unsigned fill_level = 0;
    logic [CAP_W-1:0] capacity_reg = 5'd16;

    out_item_t pending_results [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit gaps_on = 1'b1;

    bounded_lifo_stack #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (WORD_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Work out every result one accepted command causes and queue them in order.
    function automatic void predict_stack_results(in_item_t cmd_item);
        out_item_t r;
        int unsigned lim;
        int unsigned idx;
        lim = (capacity_reg > STACK_DEPTH) ? STACK_DEPTH : capacity_reg;
        r = '0;
        r.last_of_run = 1'b1;
        r.status = STAT_OK;
        case (cmd_item.cmd)
            CMD_PUSH:
            begin
                if (fill_level >= lim)
                    r.status = STAT_FULL;
                else
                begin
                    held_words[fill_level[IDX_W-1:0]] = cmd_item.push_value;
                    fill_level++;
                end
            end
            CMD_POP:
            begin
                if (fill_level == 0)
                    r.status = STAT_EMPTY;
                else
                    fill_level--;
            end
            CMD_PEEK:
            begin
                if (fill_level == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    idx = fill_level - 1;
                    r.data_word = held_words[idx[IDX_W-1:0]];
                end
            end
            CMD_DUMP_UP, CMD_DUMP_DOWN:
            begin
                if (fill_level == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // one result per held entry, last flag on the final one
                    for (int unsigned i = 0; i < fill_level; i++)
                    begin
                        idx = (cmd_item.cmd == CMD_DUMP_UP) ? i : fill_level - 1 - i;
                        r.data_word = held_words[idx[IDX_W-1:0]];
                        r.last_of_run = (i + 1 == fill_level);
                        r.entry_count = fill_level[COUNT_W-1:0];
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
            default: ; // unused codes change nothing, one plain OK result
        endcase
        r.entry_count = fill_level[COUNT_W-1:0];
        pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(string field, longint exp_val, longint act_val);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, field, exp_val, act_val);
    endtask

    // Monitor: all signals read here are the values seen by the DUT at this edge.
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg = cfg_data;
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, result);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result.data_word !== exp_r.data_word)
                        report_mismatch("data_word", exp_r.data_word, result.data_word);
                    if (result.status !== exp_r.status)
                        report_mismatch("status", exp_r.status, result.status);
                    if (result.last_of_run !== exp_r.last_of_run)
                        report_mismatch("last_of_run", exp_r.last_of_run, result.last_of_run);
                    if (result.entry_count !== exp_r.entry_count)
                        report_mismatch("entry_count", exp_r.entry_count, result.entry_count);
                end
            end
            if (start && !busy)
                predict_stack_results(item);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("[bounded_lifo_stack] ERROR");
            $finish;
        end
    end

    // Present one command and hold it until the transfer happens. start stays high
    // afterwards so back-to-back commands need no dead cycle.
    task automatic send_cmd(logic [2:0] code, logic signed [WORD_W-1:0] value);
        in_item_t next_item;
        next_item.cmd = code;
        next_item.push_value = value;
        if (gaps_on)
        begin
            while ($urandom_range(99) < GAP_PERCENT)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        item <= next_item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and wait for every expected result, plus the block's latency.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // Pop, peek and both dumps on an empty stack, plus the unused codes.
    task automatic test_empty_stack;
        send_cmd(CMD_POP, rand_word());
        send_cmd(CMD_PEEK, rand_word());
        send_cmd(CMD_DUMP_UP, rand_word());
        send_cmd(CMD_DUMP_DOWN, rand_word());
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            send_cmd(c[2:0], rand_word());
    endtask

    // Extreme and alternating words pushed, then read back every way.
    task automatic test_word_extremes;
        send_cmd(CMD_PUSH, 32'sh8000_0000);
        send_cmd(CMD_PUSH, 32'sh7fff_ffff);
        send_cmd(CMD_PUSH, '0);
        send_cmd(CMD_PUSH, -1);
        send_cmd(CMD_PUSH, 32'sh5555_5555);
        send_cmd(CMD_PUSH, 32'shaaaa_aaaa);
        send_cmd(CMD_PEEK, '0);
        send_cmd(CMD_DUMP_UP, '0);
        send_cmd(CMD_DUMP_DOWN, -1);
        send_cmd(CMD_POP, '0);
    endtask

    // Capacity lowered below the fill level, capacity zero, capacity above depth.
    task automatic test_capacity_limits;
        write_capacity(5'd1);
        send_cmd(CMD_PUSH, 32'sh1234_5678);
        send_cmd(CMD_POP, '0);
        send_cmd(CMD_DUMP_DOWN, '0);
        write_capacity(5'd0);
        send_cmd(CMD_PUSH, -1);
        send_cmd(CMD_PEEK, '0);
        write_capacity(5'd31);
        send_cmd(CMD_PUSH, 32'sh0f0f_0f0f);
    endtask

    // Random mix weighted toward pushes so the stack regularly reaches full.
    task automatic test_random_traffic(int unsigned count);
        int unsigned pick;
        logic [2:0] code;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                code = CMD_PUSH;
            else if (pick < 60)
                code = CMD_POP;
            else if (pick < 72)
                code = CMD_PEEK;
            else if (pick < 80)
                code = CMD_DUMP_UP;
            else if (pick < 88)
                code = CMD_DUMP_DOWN;
            else
                code = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            send_cmd(code, rand_word());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_word_extremes();
        test_capacity_limits();

        write_capacity(5'd16);
        test_random_traffic(60);
        write_capacity(5'd1);
        test_random_traffic(50);
        write_capacity(5'd0);
        test_random_traffic(30);
        // long stretch with no gaps on the command side
        gaps_on = 1'b0;
        write_capacity(5'd31);
        test_random_traffic(80);
        gaps_on = 1'b1;
        write_capacity(5'd2);
        test_random_traffic(50);
        write_capacity(CAP_W'($urandom_range(15, 3)));
        test_random_traffic(60);
        write_capacity(5'd16);
        test_random_traffic(70);

        drain();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, pending_results.size());
        end
        if (error_count == 0)
            $display("[bounded_lifo_stack] OK");
        else
            $display("[bounded_lifo_stack] ERROR");
        $finish;
    end

endmodule
